FILE: rtl/core/billboard_cull_and_view_transform_core_macros.svh
// Assertion macros shared by the billboard cull and view transform RTL.
`ifndef BILLBOARD_CULL_AND_VIEW_TRANSFORM_CORE_MACROS_SVH
`define BILLBOARD_CULL_AND_VIEW_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define BCVT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked across reset.
`define BCVT_ASSERT_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bcvt_pkg.sv
// Shared constants, register codes and stage payload types for the billboard core.
`default_nettype none
package bcvt_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int ROT_FRAC_BITS   = 14;
   localparam int COORD_W         = 24;
   localparam int SCALE_W         = 12;
   localparam int SLOT_W          = 8;
   localparam int ROT_W           = 16;
   localparam int ROW_W           = 3 * ROT_W;
   localparam int HW_W            = 23;
   localparam int OUT_W           = 29;
   localparam int REL_W           = COORD_W + 2;
   localparam int DELTA_W         = REL_W + 1;
   localparam int PROD_W          = ROT_W + DELTA_W;
   localparam int SUM_W           = PROD_W + 2;
   localparam int HALF_NUM        = 922;
   localparam int HALF_NUM_W      = 10;
   localparam int HALF_SHIFT      = 10;
   localparam int REQ_DATA_W      = 96;
   localparam int RSP_DATA_W      = 104;
   localparam int RSP_PAD_W       = RSP_DATA_W - 3 * OUT_W - 2 - SLOT_W;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = ROW_W;

   localparam logic [ROW_W-1:0] ROT_P_RESET = ROW_W'(1) << ROT_FRAC_BITS;
   localparam logic [ROW_W-1:0] ROT_Q_RESET = ROW_W'(1) << (ROT_FRAC_BITS + ROT_W);
   localparam logic [ROW_W-1:0] ROT_R_RESET = ROW_W'(1) << (ROT_FRAC_BITS + 2 * ROT_W);
   localparam logic [HW_W-1:0]  CULL_RESET  = HW_W'(1000 << COORD_FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_P,
      CSR_ROT_Q,
      CSR_ROT_R,
      CSR_CAM_X,
      CSR_CAM_Y,
      CSR_CAM_Z,
      CSR_TRUNK,
      CSR_CULL_HW
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]          rot_p;
      logic [ROW_W-1:0]          rot_q;
      logic [ROW_W-1:0]          rot_r;
      logic signed [COORD_W-1:0] cam_x;
      logic signed [COORD_W-1:0] cam_y;
      logic signed [COORD_W-1:0] cam_z;
      logic signed [COORD_W-1:0] trunk;
      logic [HW_W-1:0]           cull_hw;
   } cfg_type;

   // One kept object, already made relative to the camera.
   typedef struct packed {
      logic signed [REL_W-1:0] rel_x;
      logic signed [REL_W-1:0] rel_y;
      logic signed [REL_W-1:0] rel_z;
      logic [SCALE_W-1:0]      half;
      logic [SCALE_W:0]        height;
      logic [SLOT_W-1:0]       slot;
   } obj_type;

   typedef struct packed {
      logic              tex_u;
      logic              tex_v;
      logic              quad_sel;
      logic              corner_last;
      logic [SLOT_W-1:0] slot;
   } tag_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [DELTA_W-1:0] dz;
      tag_type                   tag;
   } corner_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] view_x;
      logic signed [OUT_W-1:0] view_y;
      logic signed [OUT_W-1:0] view_z;
      tag_type                 tag;
   } vertex_type;

   function automatic logic signed [ROT_W-1:0] row_entry(input logic [ROW_W-1:0] row,
                                                         input int k);
      row_entry = signed'(row[k*ROT_W +: ROT_W]);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bcvt_front.sv
// Front stage: cull test, camera-relative position and quad size of each object.
`default_nettype none
module bcvt_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bcvt_pkg::cfg_type               cfg,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [bcvt_pkg::REQ_DATA_W-1:0] in_data,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output bcvt_pkg::obj_type                    out_obj
);
   import bcvt_pkg::*;

   logic signed [COORD_W-1:0]           obj_x;
   logic signed [COORD_W-1:0]           obj_y;
   logic signed [COORD_W-1:0]           obj_z;
   logic [SCALE_W-1:0]                  obj_scale;
   logic [SLOT_W-1:0]                   tex_index;
   logic signed [REL_W-1:0]             hw_s;
   logic [SCALE_W+HALF_NUM_W-1:0]       half_prod;
   logic                                keep;
   logic                                valid_ff, valid_in;
   obj_type                             obj_ff, obj_in;

   assign obj_x     = signed'(in_data[COORD_W-1:0]);
   assign obj_y     = signed'(in_data[2*COORD_W-1:COORD_W]);
   assign obj_z     = signed'(in_data[3*COORD_W-1:2*COORD_W]);
   assign obj_scale = in_data[3*COORD_W +: SCALE_W];
   assign tex_index = in_data[3*COORD_W+SCALE_W +: SLOT_W];

   always_comb begin
      hw_s         = REL_W'(cfg.cull_hw);
      obj_in.rel_x = REL_W'(obj_x) - REL_W'(cfg.cam_x);
      obj_in.rel_y = REL_W'(obj_y) - REL_W'(cfg.cam_y);
      obj_in.rel_z = REL_W'(obj_z) - REL_W'(cfg.trunk) - REL_W'(cfg.cam_z);
      half_prod    = (SCALE_W+HALF_NUM_W)'(obj_scale) * (SCALE_W+HALF_NUM_W)'(HALF_NUM);
      obj_in.half  = half_prod[HALF_SHIFT +: SCALE_W];
      obj_in.height = {obj_scale, 1'b0};
      obj_in.slot  = tex_index;
      // Strict square window: an object exactly on the edge is dropped.
      keep = (obj_in.rel_x < hw_s) && (obj_in.rel_x > -hw_s) &&
             (obj_in.rel_y < hw_s) && (obj_in.rel_y > -hw_s);
      valid_in = in_valid && keep;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_obj   = obj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && valid_in) begin
         obj_ff <= obj_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bcvt_corner_seq.sv
// Corner sequencer: issues the eight corner deltas of one object, one per cycle while out_ready allows.
`default_nettype none
module bcvt_corner_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire bcvt_pkg::obj_type    in_obj,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output bcvt_pkg::corner_type      out_corner
);
   import bcvt_pkg::*;

   logic                      hold_valid_ff;
   obj_type                   obj_ff;
   logic [2:0]                count_ff;
   logic                      cv_ff;
   corner_type                corner_ff, corner_in;
   logic                      advance, finish;
   logic [1:0]                cidx;
   logic                      minus, top;
   logic signed [DELTA_W-1:0] half_s, off, rx, ry, rz, height_s;

   assign advance  = hold_valid_ff && (!cv_ff || out_ready);
   assign finish   = advance && (&count_ff);
   assign in_ready = !hold_valid_ff || finish;

   always_comb begin
      cidx     = count_ff[1:0];
      // Corner order in a quad: top-minus, top-plus, bottom-plus, bottom-minus.
      minus    = (cidx[0] == cidx[1]);
      top      = !cidx[1];
      half_s   = DELTA_W'(obj_ff.half);
      height_s = DELTA_W'(obj_ff.height);
      off      = minus ? -half_s : half_s;
      rx       = DELTA_W'(obj_ff.rel_x);
      ry       = DELTA_W'(obj_ff.rel_y);
      rz       = DELTA_W'(obj_ff.rel_z);
      corner_in.dx = count_ff[2] ? rx : rx + off;
      corner_in.dy = count_ff[2] ? ry + off : ry;
      corner_in.dz = top ? rz + height_s : rz;
      corner_in.tag.tex_u       = cidx[0] ^ cidx[1];
      corner_in.tag.tex_v       = cidx[1];
      corner_in.tag.quad_sel    = count_ff[2];
      corner_in.tag.corner_last = &count_ff;
      corner_in.tag.slot        = obj_ff.slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         cv_ff         <= 1'b0;
      end else begin
         if (in_ready) begin
            hold_valid_ff <= in_valid;
         end
         if (advance) begin
            count_ff <= count_ff + 3'd1;
         end
         if (!cv_ff || out_ready) begin
            cv_ff <= hold_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         obj_ff <= in_obj;
      end
      if (advance) begin
         corner_ff <= corner_in;
      end
   end

   assign out_valid  = cv_ff;
   assign out_corner = corner_ff;

endmodule
`default_nettype wire

FILE: rtl/core/bcvt_dot.sv
// Two-stage rotation unit: nine registered products, then three sums into the output register.
`default_nettype none
module bcvt_dot (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcvt_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire bcvt_pkg::corner_type in_corner,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output bcvt_pkg::vertex_type      out_vertex
);
   import bcvt_pkg::*;

   logic [ROW_W-1:0]          rows [3];
   logic signed [DELTA_W-1:0] deltas [3];
   logic signed [PROD_W-1:0]  prod_in [3][3];
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [SUM_W-1:0]   sums [3];
   tag_type                   tag_ff;
   logic                      pv_ff, ov_ff;
   logic                      p_ready, o_ready;
   vertex_type                vertex_ff, vertex_in;

   assign rows[0]   = cfg.rot_p;
   assign rows[1]   = cfg.rot_q;
   assign rows[2]   = cfg.rot_r;
   assign deltas[0] = in_corner.dx;
   assign deltas[1] = in_corner.dy;
   assign deltas[2] = in_corner.dz;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = PROD_W'(row_entry(rows[r], k)) * PROD_W'(deltas[k]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sums[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
      end
      // Arithmetic shift by the rotation fraction rounds toward minus infinity.
      vertex_in.view_x = sums[0][ROT_FRAC_BITS +: OUT_W];
      vertex_in.view_y = sums[1][ROT_FRAC_BITS +: OUT_W];
      vertex_in.view_z = sums[2][ROT_FRAC_BITS +: OUT_W];
      vertex_in.tag    = tag_ff;
   end

   assign o_ready  = !ov_ff || out_ready;
   assign p_ready  = !pv_ff || o_ready;
   assign in_ready = p_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            pv_ff <= in_valid;
         end
         if (o_ready) begin
            ov_ff <= pv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && in_valid) begin
         prod_ff <= prod_in;
         tag_ff  <= in_corner.tag;
      end
      if (o_ready && pv_ff) begin
         vertex_ff <= vertex_in;
      end
   end

   assign out_valid  = ov_ff;
   assign out_vertex = vertex_ff;

endmodule
`default_nettype wire

FILE: rtl/core/billboard_cull_and_view_transform_core.sv
// A kept object's first corner reaches rsp_tvalid through the front register, the sequencer's
// object and corner registers, then the product and output registers. Its eight corners follow
// on consecutive cycles when rsp_tready stays high. Throughput: one corner per cycle while
// rsp_tready is high, issued by the corner sequencer into a single shared set of nine multipliers.
// Reset is synchronous and active high: it empties every stage and loads register defaults.
`default_nettype none
`include "billboard_cull_and_view_transform_core_macros.svh"
module billboard_cull_and_view_transform_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Object items: obj_x[23:0], obj_y[47:24], obj_z[71:48], obj_scale[83:72],
   // tex_index[91:84], zero fill[95:92].
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [bcvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // Corner items: view_x[28:0], view_y[57:29], view_z[86:58], tex_u[87], tex_v[88],
   // tex_slot[96:89], zero fill[103:97].
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [bcvt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // quad_sel[0].
   output logic                                 rsp_tuser,
   // High on the eighth corner of an object.
   output logic                                 rsp_tlast,
   // Register writes; csr_index follows the register codes of the package.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bcvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bcvt_pkg::CSR_DATA_W-1:0] csr_data
);
   import bcvt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       front_valid, front_ready;
   obj_type    front_obj;
   logic       seq_valid, seq_ready;
   corner_type seq_corner;
   vertex_type vertex;

   // The register file takes a write in every cycle. The user must make writes only while the
   // pipeline is empty, which the block does not enforce; the stages read the registers directly.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ROT_P:   cfg_in.rot_p   = csr_data;
            CSR_ROT_Q:   cfg_in.rot_q   = csr_data;
            CSR_ROT_R:   cfg_in.rot_r   = csr_data;
            CSR_CAM_X:   cfg_in.cam_x   = csr_data[COORD_W-1:0];
            CSR_CAM_Y:   cfg_in.cam_y   = csr_data[COORD_W-1:0];
            CSR_CAM_Z:   cfg_in.cam_z   = csr_data[COORD_W-1:0];
            CSR_TRUNK:   cfg_in.trunk   = csr_data[COORD_W-1:0];
            CSR_CULL_HW: cfg_in.cull_hw = csr_data[HW_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_p   <= ROT_P_RESET;
         cfg_ff.rot_q   <= ROT_Q_RESET;
         cfg_ff.rot_r   <= ROT_R_RESET;
         cfg_ff.cam_x   <= '0;
         cfg_ff.cam_y   <= '0;
         cfg_ff.cam_z   <= '0;
         cfg_ff.trunk   <= '0;
         cfg_ff.cull_hw <= CULL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage 1: cull test and camera-relative object. Culled objects never enter the pipeline.
   bcvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_obj   (front_obj)
   );

   // Stage 2: the sequencer holds one object and emits its corners in order.
   // The front stage buffers the next object meanwhile.
   bcvt_corner_seq u_corner_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (front_valid),
      .in_ready   (front_ready),
      .in_obj     (front_obj),
      .out_valid  (seq_valid),
      .out_ready  (seq_ready),
      .out_corner (seq_corner)
   );

   // Stages 3 and 4: products, then sums into the output register.
   bcvt_dot u_dot (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (seq_valid),
      .in_ready   (seq_ready),
      .in_corner  (seq_corner),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_vertex (vertex)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, vertex.tag.slot, vertex.tag.tex_v, vertex.tag.tex_u,
                       vertex.view_z, vertex.view_y, vertex.view_x};
   assign rsp_tuser = vertex.tag.quad_sel;
   assign rsp_tlast = vertex.tag.corner_last;

   // The last corner of an object is exactly the bottom-minus corner of the y-spanning quad.
   `BCVT_ASSERT_IMP(a_last_corner, clock, reset, rsp_tvalid,
                    rsp_tlast == (rsp_tuser && !rsp_tdata[87] && rsp_tdata[88]),
                    "corner_last does not match the corner position")
   // After reset, no corner is offered.
   `BCVT_ASSERT_NXT(a_reset_empty, clock, reset, !rsp_tvalid,
                    "corner offered right after reset")

endmodule
`default_nettype wire
